// ===== sv/pfp_pkg.sv =====
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types, byte codes and match strings for the printer feedback parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfp_pkg;

  // Control bytes from the printer
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_XON  = 8'h11;
  localparam logic [7:0] CH_XOFF = 8'h13;

  // Printable ranges: 0x20-0x7E and 0xA0-0xFF
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_C1_HI    = 8'h9F;

  // Status prefix and flush message
  localparam int PREFIX_LEN = 12;
  localparam logic [8*PREFIX_LEN-1:0] PREFIX_TEXT = "%%[ status: ";
  localparam int FLUSH_LEN = 62;
  localparam logic [8*FLUSH_LEN-1:0] FLUSH_TEXT =
    "%%[ Flushing: rest of job (to end-of-file) will be ignored ]%%";

  // Longest line length reported
  localparam int LEN_MAX = 255;

  typedef enum logic [2:0] {
    EV_CHAR   = 3'd0,
    EV_LINE   = 3'd1,
    EV_RESUME = 3'd2,
    EV_PAUSE  = 3'd3,
    EV_DONE   = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    CLS_STATUS = 2'd0,
    CLS_MSG    = 2'd1,
    CLS_FLUSH  = 2'd2
  } line_class_t;

  // One result beat
  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  ch;
    logic        present;
    line_class_t cls;
    logic [7:0]  len;
    logic        had;
  } res_t;

  // Character of the status prefix at a position (0 past the end)
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] ch;
    ch = '0;
    for (int i = 0; i < PREFIX_LEN; i++) begin
      if (idx == 4'(i)) ch = PREFIX_TEXT[8*(PREFIX_LEN-1-i) +: 8];
    end
    return ch;
  endfunction

  // Character of the flush message at a position (0 past the end)
  function automatic logic [7:0] flush_char(input logic [5:0] idx);
    logic [7:0] ch;
    ch = '0;
    for (int i = 0; i < FLUSH_LEN; i++) begin
      if (idx == 6'(i)) ch = FLUSH_TEXT[8*(FLUSH_LEN-1-i) +: 8];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== sv/printer_feedback_parser.sv =====
// ----------------------------------------------------------------------------
// printer_feedback_parser
// Byte-at-a-time parser for the feedback stream of a serial printer.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while rx_stall is low and gives
// at most one registered event beat per byte. Every byte is decoded by
// a single level of compare logic against the line state registers (held
// count, the two running string matches, CR seen, messages seen), so the rate
// is one byte per clock with no gaps while rx_stall is low. Event beats go
// through an output register backed by one skid entry; rx_stall rises only
// when both are full. Bytes that cause no event (garbage, LF after CR,
// characters past the buffer limit) still update state and produce no beat.
`timescale 1ns / 1ps
`default_nettype none

module printer_feedback_parser #(
  parameter int MSG_BUF_LEN = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // receive channel
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] rx_byte,
  // event channel
  output logic            ev_valid,
  input  wire logic       ev_stall,
  output logic [2:0]      event_kind,
  output logic [7:0]      msg_char,
  output logic            line_present,
  output logic [1:0]      line_class,
  output logic [7:0]      line_length,
  output logic            job_had_messages
);

  localparam int HELD_W = $clog2(MSG_BUF_LEN);

  // line state
  logic [HELD_W-1:0] held_count, held_count_next;
  logic              prefix_match_ok, prefix_match_ok_next;
  logic              flush_match_ok, flush_match_ok_next;
  logic              after_carriage_return, after_carriage_return_next;
  logic              messages_seen, messages_seen_next;

  // output register and skid entry
  pfp_pkg::res_t out_reg, skid_reg, res;
  logic          skid_valid;
  logic          res_has;
  logic          rx_take, out_free;

  // close-line terms
  logic                is_status;
  pfp_pkg::line_class_t close_cls;
  logic [7:0]          close_len;
  logic                seen_after;
  logic                printable;

  assign rx_take  = rx_valid && !skid_valid;
  assign out_free = !ev_valid || !ev_stall;
  assign rx_stall = skid_valid;

  // Classify the line held so far
  always_comb begin
    is_status  = prefix_match_ok && (32'(held_count) >= 32'(pfp_pkg::PREFIX_LEN));
    if (is_status) begin
      close_cls = pfp_pkg::CLS_STATUS;
    end else if (flush_match_ok && (32'(held_count) == 32'(pfp_pkg::FLUSH_LEN))) begin
      close_cls = pfp_pkg::CLS_FLUSH;
    end else begin
      close_cls = pfp_pkg::CLS_MSG;
    end
    if (32'(held_count) > 32'(pfp_pkg::LEN_MAX)) begin
      close_len = 8'(pfp_pkg::LEN_MAX);
    end else begin
      close_len = 8'(32'(held_count));
    end
    seen_after = messages_seen || !is_status;
    printable  = (rx_byte == pfp_pkg::CH_TAB) ||
                 ((rx_byte >= pfp_pkg::CH_PRINT_LO) &&
                  !((rx_byte >= pfp_pkg::CH_DEL) && (rx_byte <= pfp_pkg::CH_C1_HI)));
  end

  // Byte decode and next state
  always_comb begin
    res                        = '0;
    res.kind                   = pfp_pkg::EV_CHAR;
    res.cls                    = pfp_pkg::CLS_STATUS;
    res.had                    = messages_seen;
    res_has                    = 1'b0;
    held_count_next            = held_count;
    prefix_match_ok_next       = prefix_match_ok;
    flush_match_ok_next        = flush_match_ok;
    after_carriage_return_next = after_carriage_return;
    messages_seen_next         = messages_seen;

    unique case (rx_byte)
      pfp_pkg::CH_EOT: begin
        res_has  = 1'b1;
        res.kind = pfp_pkg::EV_DONE;
        if (held_count != '0) begin
          res.present = 1'b1;
          res.cls     = close_cls;
          res.len     = close_len;
          res.had     = seen_after;
        end
        // new job
        held_count_next            = '0;
        prefix_match_ok_next       = 1'b1;
        flush_match_ok_next        = 1'b1;
        after_carriage_return_next = 1'b0;
        messages_seen_next         = 1'b0;
      end
      pfp_pkg::CH_LF, pfp_pkg::CH_CR: begin
        if (rx_byte == pfp_pkg::CH_LF && after_carriage_return) begin
          // LF of a CR LF pair
          after_carriage_return_next = 1'b0;
        end else begin
          res_has     = 1'b1;
          res.kind    = pfp_pkg::EV_LINE;
          res.present = 1'b1;
          res.cls     = close_cls;
          res.len     = close_len;
          res.had     = seen_after;
          messages_seen_next         = seen_after;
          held_count_next            = '0;
          prefix_match_ok_next       = 1'b1;
          flush_match_ok_next        = 1'b1;
          after_carriage_return_next = (rx_byte == pfp_pkg::CH_CR);
        end
      end
      pfp_pkg::CH_XON: begin
        res_has  = 1'b1;
        res.kind = pfp_pkg::EV_RESUME;
      end
      pfp_pkg::CH_XOFF: begin
        res_has  = 1'b1;
        res.kind = pfp_pkg::EV_PAUSE;
      end
      default: begin
        after_carriage_return_next = 1'b0;
        if (printable && (held_count < HELD_W'(MSG_BUF_LEN - 1))) begin
          if ((32'(held_count) < 32'(pfp_pkg::PREFIX_LEN)) &&
              (rx_byte != pfp_pkg::prefix_char(held_count[3:0]))) begin
            prefix_match_ok_next = 1'b0;
          end
          if ((32'(held_count) >= 32'(pfp_pkg::FLUSH_LEN)) ||
              (rx_byte != pfp_pkg::flush_char(held_count[5:0]))) begin
            flush_match_ok_next = 1'b0;
          end
          held_count_next = held_count + 1'b1;
          res_has  = 1'b1;
          res.kind = pfp_pkg::EV_CHAR;
          res.ch   = rx_byte;
        end
      end
    endcase
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count            <= '0;
      prefix_match_ok       <= 1'b1;
      flush_match_ok        <= 1'b1;
      after_carriage_return <= 1'b0;
      messages_seen         <= 1'b0;
    end else if (rx_take) begin
      held_count            <= held_count_next;
      prefix_match_ok       <= prefix_match_ok_next;
      flush_match_ok        <= flush_match_ok_next;
      after_carriage_return <= after_carriage_return_next;
      messages_seen         <= messages_seen_next;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        ev_valid   <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (rx_take && res_has) begin
      if (out_free) begin
        ev_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      ev_valid <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) out_reg <= skid_reg;
    end else if (rx_take && res_has) begin
      if (out_free) begin
        out_reg <= res;
      end else begin
        skid_reg <= res;
      end
    end
  end

  assign event_kind       = out_reg.kind;
  assign msg_char         = out_reg.ch;
  assign line_present     = out_reg.present;
  assign line_class       = out_reg.cls;
  assign line_length      = out_reg.len;
  assign job_had_messages = out_reg.had;

endmodule

`default_nettype wire

// ===== sv/pfp_check.sv =====
// ----------------------------------------------------------------------------
// pfp_check
// Port-level checks for the printer feedback parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfp_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rx_valid,
  input wire logic       rx_stall,
  input wire logic [7:0] rx_byte,
  input wire logic       ev_valid,
  input wire logic       ev_stall,
  input wire logic [2:0] event_kind,
  input wire logic [7:0] msg_char,
  input wire logic       line_present,
  input wire logic [1:0] line_class,
  input wire logic [7:0] line_length,
  input wire logic       job_had_messages
);

  // a stalled event beat stays
  a_ev_hold: assert property (@(posedge clk) disable iff (rst)
    ev_valid && ev_stall |=> ev_valid && $stable(event_kind) && $stable(msg_char))
    else $error("event beat dropped or changed while stalled");

  // receive side only backs up when the output side is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> ev_valid)
    else $error("rx_stall with no event pending");

  // a line-ended beat always carries a line
  a_line_present: assert property (@(posedge clk) disable iff (rst)
    ev_valid && event_kind == pfp_pkg::EV_LINE |-> line_present)
    else $error("line event without a line");

  // a logged line sets the messages flag
  a_logged_flag: assert property (@(posedge clk) disable iff (rst)
    ev_valid && line_present && line_class != pfp_pkg::CLS_STATUS |-> job_had_messages)
    else $error("logged line without messages flag");

endmodule

bind printer_feedback_parser pfp_check u_pfp_check (.*);

`default_nettype wire
